FILE: rtl/hhls_pkg.sv
// Package for the HTTP header length scanner: beat types, control struct,
// character constants and the keyword table. No dependencies.
`timescale 1ns / 1ps

package hhls_pkg;

   // Largest request buffer in bytes; the body count saturates four below it.
   localparam int MAX_REQUEST_BYTES = 65536;
   localparam int BODY_LIMIT_RAW    = (MAX_REQUEST_BYTES > 4) ? MAX_REQUEST_BYTES - 4 : 0;
   localparam logic [15:0] BODY_LIMIT =
      (BODY_LIMIT_RAW > 65535) ? 16'hFFFF : 16'(BODY_LIMIT_RAW);

   // Keyword "content-length:" is fifteen characters; progress code fifteen
   // means the colon has matched and no byte has followed yet.
   localparam int          KEY_LEN          = 15;
   localparam logic [3:0]  WAIT_AFTER_COLON = 4'd15;

   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_LF      = 8'h0A;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_C = 8'h63;
   localparam logic [7:0] CHAR_CASE    = 8'h20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_beat_type;

   typedef struct packed {
      logic        length_found;
      logic [31:0] declared_length;
      logic        header_end_found;
      logic [15:0] body_bytes;
   } rsp_beat_type;

   // Step control shared by the scan units.
   typedef struct packed {
      logic advance;
      logic is_last;
   } hhls_step_type;

   // Lowercase keyword character at a progress index.
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h63; // c
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h6C; // l
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Fold uppercase letters to lowercase; other bytes pass unchanged.
   function automatic logic [7:0] fold_case(input logic [7:0] b);
      logic [7:0] f;
      if (b inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         f = b | CHAR_CASE;
      end else begin
         f = b;
      end
      return f;
   endfunction

endpackage

FILE: rtl/hhls_length_scan.sv
// Content-length keyword matcher and saturating decimal accumulator.
// Depends on hhls_pkg.
`timescale 1ns / 1ps

module hhls_length_scan (
   input  logic                   clock,
   input  logic                   reset,
   input  hhls_pkg::hhls_step_type step,
   input  logic [7:0]             data_byte,
   output logic                   length_found,
   output logic [31:0]            declared_length
);

   logic [3:0]  progress_ff, progress_in;
   logic        matched_ff, matched_in;
   logic        ended_ff, ended_in;
   logic [31:0] value_ff, value_in;

   logic [7:0]  folded;
   logic        is_crlf;
   logic        is_digit;
   logic        take;
   logic [35:0] product;

   assign folded   = hhls_pkg::fold_case(data_byte);
   assign is_crlf  = (data_byte == hhls_pkg::CHAR_CR) || (data_byte == hhls_pkg::CHAR_LF);
   assign is_digit = data_byte inside {[hhls_pkg::CHAR_ZERO:hhls_pkg::CHAR_NINE]};

   // value * 10 + digit; the digit is the low nibble of an ASCII digit
   assign product = {1'b0, value_ff, 3'b000} + {3'b000, value_ff, 1'b0}
                  + {32'd0, data_byte[3:0]};

   always_comb begin
      progress_in = progress_ff;
      matched_in  = matched_ff;
      ended_in    = ended_ff;
      value_in    = value_ff;
      take        = 1'b0;
      if (matched_ff) begin
         take = 1'b1;
      end else if (progress_ff == hhls_pkg::WAIT_AFTER_COLON) begin
         matched_in = 1'b1;
         take       = 1'b1;
      end else if (folded == hhls_pkg::key_char(progress_ff)) begin
         progress_in = progress_ff + 4'd1;
      end else if (folded == hhls_pkg::CHAR_LOWER_C) begin
         progress_in = 4'd1;
      end else begin
         progress_in = '0;
      end
      if (take && !ended_ff) begin
         if (is_crlf) begin
            ended_in = 1'b1;
         end else if (is_digit) begin
            value_in = (product[35:32] != 4'd0) ? 32'hFFFF_FFFF : product[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.is_last)) begin
         progress_ff <= '0;
         matched_ff  <= 1'b0;
         ended_ff    <= 1'b0;
         value_ff    <= '0;
      end else if (step.advance) begin
         progress_ff <= progress_in;
         matched_ff  <= matched_in;
         ended_ff    <= ended_in;
         value_ff    <= value_in;
      end
   end

   assign length_found    = matched_in;
   assign declared_length = matched_in ? value_in : 32'd0;

endmodule

FILE: rtl/hhls_header_end.sv
// Header end detector (four CR/LF bytes in a row) and body byte counter.
// Depends on hhls_pkg.
`timescale 1ns / 1ps

module hhls_header_end (
   input  logic                   clock,
   input  logic                   reset,
   input  hhls_pkg::hhls_step_type step,
   input  logic [7:0]             data_byte,
   output logic                   header_end_found,
   output logic [15:0]            body_bytes
);

   logic [1:0]  run_ff, run_in;
   logic        seen_ff, seen_in;
   logic [15:0] count_ff, count_in;
   logic        is_crlf;

   assign is_crlf = (data_byte == hhls_pkg::CHAR_CR) || (data_byte == hhls_pkg::CHAR_LF);

   always_comb begin
      run_in   = run_ff;
      seen_in  = seen_ff;
      count_in = count_ff;
      if (seen_ff) begin
         if (count_ff < hhls_pkg::BODY_LIMIT) begin
            count_in = count_ff + 16'd1;
         end
      end else if (is_crlf) begin
         if (run_ff == 2'd3) begin
            seen_in = 1'b1;
         end else begin
            run_in = run_ff + 2'd1;
         end
      end else begin
         run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.is_last)) begin
         run_ff   <= '0;
         seen_ff  <= 1'b0;
         count_ff <= '0;
      end else if (step.advance) begin
         run_ff   <= run_in;
         seen_ff  <= seen_in;
         count_ff <= count_in;
      end
   end

   assign header_end_found = seen_in;
   assign body_bytes       = seen_in ? count_in : 16'd0;

endmodule

FILE: rtl/http_header_length_scanner.sv
// Path: a last beat is held in the input stage, then its result is registered
// in the result register that drives rsp_, once that register is free.
// Throughput: one byte per clock; a result beat waiting on rsp_stall blocks
// only the next last beat, non-last beats keep flowing through the scan units.
// Reset: synchronous, active high; clears the input stage, result valid and
// all scan state. Scan state also returns to reset after every last beat.
`timescale 1ns / 1ps

module http_header_length_scanner (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  hhls_pkg::req_beat_type req_beat,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output hhls_pkg::rsp_beat_type rsp_beat
);

   // Input stage: one registered beat
   logic                   s1_valid_ff, s1_valid_in;
   hhls_pkg::req_beat_type s1_beat_ff;

   // Result stage
   logic                   rsp_valid_ff, rsp_valid_in;
   hhls_pkg::rsp_beat_type rsp_beat_ff;
   hhls_pkg::rsp_beat_type result;

   logic                   req_accept;
   logic                   out_free;
   logic                   s1_advance;
   hhls_pkg::hhls_step_type step;

   // The result register is free when empty or being drained this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   // A non-last beat never produces a result, so it always advances;
   // a last beat needs room in the result register.
   assign s1_advance = s1_valid_ff && (!s1_beat_ff.is_last || out_free);
   assign req_stall  = s1_valid_ff && !s1_advance;
   assign req_accept = req_valid && !req_stall;

   assign step.advance = s1_advance;
   assign step.is_last = s1_beat_ff.is_last;

   // Hold the beat when stalled, load a new one whenever accepted, drop
   // the valid when the held beat advances without a replacement.
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_beat_ff <= req_beat;
      end
   end

   // Keyword match and digit accumulation
   hhls_length_scan u_length_scan (
      .clock           (clock),
      .reset           (reset),
      .step            (step),
      .data_byte       (s1_beat_ff.data_byte),
      .length_found    (result.length_found),
      .declared_length (result.declared_length)
   );

   // Blank-line detection and body count
   hhls_header_end u_header_end (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .data_byte        (s1_beat_ff.data_byte),
      .header_end_found (result.header_end_found),
      .body_bytes       (result.body_bytes)
   );

   // Capture the result on the last beat; clear valid once taken.
   always_comb begin
      if (s1_advance && s1_beat_ff.is_last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_beat_ff.is_last) begin
         rsp_beat_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   // A last beat leaving the input stage always yields a result beat.
   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      s1_advance && s1_beat_ff.is_last |=> rsp_valid_ff)
      else $error("last beat advanced without a result");

   // The input side only stalls behind a held beat.
   a_stall_needs_beat : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty stage");

   // A missing keyword reports a zero length.
   a_length_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_beat_ff.length_found |-> rsp_beat_ff.declared_length == 32'd0)
      else $error("nonzero length without keyword");

   // A missing header end reports no body bytes.
   a_body_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_beat_ff.header_end_found |-> rsp_beat_ff.body_bytes == 16'd0)
      else $error("body bytes without header end");

   // The body count never passes its saturation limit.
   a_body_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_beat_ff.body_bytes <= hhls_pkg::BODY_LIMIT)
      else $error("body count above limit");

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for http_header_length_scanner: drives request buffers
// byte by byte and checks each summary beat against a scoreboard model.
// Depends on hhls_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module tb_top;

   // Keyword packed MSB first, so character k sits at byte (14 - k).
   localparam logic [8*15-1:0] KEYWORD  = "content-length:";
   localparam logic [3:0]      KEY_DONE = 4'd15;  // colon matched, no byte after yet
   localparam int BODY_CAP =
      (hhls_pkg::MAX_REQUEST_BYTES - 4 > 65535) ? 65535 : hhls_pkg::MAX_REQUEST_BYTES - 4;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   hhls_pkg::req_beat_type req_beat;
   logic                   rsp_valid;
   logic                   rsp_stall;
   hhls_pkg::rsp_beat_type rsp_beat;

   // Traffic shaping, percent per cycle.
   int idle_pct  = 0;
   int stall_pct = 0;

   int bytes_sent     = 0;
   int mismatch_count = 0;

   // Bytes of the buffer under construction.
   logic [7:0] frame_bytes[$];

   // Summaries predicted but not yet seen on rsp_.
   hhls_pkg::rsp_beat_type pending_summaries[$];
   hhls_pkg::rsp_beat_type oldest_summary;

   // Scan state mirrored from the block.
   logic [3:0]  key_pos       = '0;
   logic        length_armed  = 1'b0;
   logic        value_closed  = 1'b0;
   logic [31:0] length_value  = '0;
   logic [2:0]  eol_run       = '0;
   logic        end_seen      = 1'b0;
   logic [15:0] body_tally    = '0;

   http_header_length_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_beat  (req_beat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_beat  (rsp_beat)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Safety net: the slowest legal run finishes far earlier than this.
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------
   // Scoreboard model
   // ------------------------------------------------------------------

   // Case-insensitive compare of one byte against keyword position pos.
   function automatic bit keyword_accepts(input logic [3:0] pos, input logic [7:0] b);
      int         idx;
      logic [7:0] want;
      idx  = 14 - int'(pos);
      want = KEYWORD[8*idx +: 8];
      if (want >= "a" && want <= "z") begin
         return (b == want) || (b == (want ^ 8'h20));
      end
      return b == want;
   endfunction

   // Advance the model by one accepted beat; queue a summary on the last one.
   task automatic track_byte(input logic [7:0] b, input logic last);
      logic                   eol;
      logic [35:0]            scaled;
      hhls_pkg::rsp_beat_type summary;
      eol = (b == hhls_pkg::CHAR_CR) || (b == hhls_pkg::CHAR_LF);

      // Keyword search stops for good once a byte follows the colon.
      if (!length_armed) begin
         if (key_pos == KEY_DONE) begin
            length_armed = 1'b1;
         end else if (keyword_accepts(key_pos, b)) begin
            key_pos = key_pos + 4'd1;
         end else begin
            key_pos = (b == "c" || b == "C") ? 4'd1 : 4'd0;
         end
      end

      // Collect digits up to the first CR or LF, skip anything else, saturate.
      if (length_armed && !value_closed) begin
         if (eol) begin
            value_closed = 1'b1;
         end else if (b >= "0" && b <= "9") begin
            scaled = 36'(length_value) * 36'd10 + 36'(b - 8'h30);
            length_value = (scaled > 36'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
         end
      end

      // Four CR/LF bytes in a row open the body; count body bytes after that.
      if (end_seen) begin
         if (body_tally < BODY_CAP) begin
            body_tally = body_tally + 16'd1;
         end
      end else if (eol) begin
         if (eol_run >= 3'd3) begin
            end_seen = 1'b1;
         end else begin
            eol_run = eol_run + 3'd1;
         end
      end else begin
         eol_run = '0;
      end

      if (last) begin
         summary.length_found     = length_armed;
         summary.declared_length  = length_armed ? length_value : 32'd0;
         summary.header_end_found = end_seen;
         summary.body_bytes       = end_seen ? body_tally : 16'd0;
         pending_summaries.push_back(summary);
         key_pos      = '0;
         length_armed = 1'b0;
         value_closed = 1'b0;
         length_value = '0;
         eol_run      = '0;
         end_seen     = 1'b0;
         body_tally   = '0;
      end
   endtask

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Drive one beat at the falling edge, hold it until accepted, then model it.
   // Valid stays high after acceptance until the next falling edge, where the
   // next call either replaces the beat or drops valid for an idle gap.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_beat.data_byte <= b;
      req_beat.is_last   <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      track_byte(b, last);
   endtask

   // Append text, flipping the case of letters at random when asked.
   task automatic add_text(input string s, input bit mix_case);
      logic [7:0] ch;
      for (int i = 0; i < s.len(); i++) begin
         ch = s[i];
         if (mix_case && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"))
             && $urandom_range(0, 1)) begin
            ch = ch ^ 8'h20;
         end
         frame_bytes.push_back(ch);
      end
   endtask

   task automatic add_crlf();
      frame_bytes.push_back(hhls_pkg::CHAR_CR);
      frame_bytes.push_back(hhls_pkg::CHAR_LF);
   endtask

   // Send the built buffer, flag its final byte, and clear it.
   task automatic send_frame();
      for (int i = 0; i < frame_bytes.size(); i++) begin
         send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
      end
      frame_bytes.delete();
   endtask

   // Drop valid and hold off until every predicted summary has been seen.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_summaries.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------

   // Random back-pressure, changed only at the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // Compare every accepted summary beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_summaries.size() == 0) begin
            $error("summary beat with nothing predicted: %p", rsp_beat);
            mismatch_count++;
         end else begin
            oldest_summary = pending_summaries.pop_front();
            check_field("length_found", 32'(oldest_summary.length_found),
                        32'(rsp_beat.length_found));
            check_field("declared_length", oldest_summary.declared_length,
                        rsp_beat.declared_length);
            check_field("header_end_found", 32'(oldest_summary.header_end_found),
                        32'(rsp_beat.header_end_found));
            check_field("body_bytes", 32'(oldest_summary.body_bytes),
                        32'(rsp_beat.body_bytes));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Byte extremes and the CR/LF run detector on its own.
   task automatic test_byte_extremes();
      frame_bytes.push_back(8'h00);
      send_frame();
      frame_bytes.push_back(8'hFF);
      send_frame();
      // Run of four ending on the last byte: end found, empty body.
      add_crlf();
      add_crlf();
      send_frame();
      // Broken run: never four in a row.
      frame_bytes.push_back(hhls_pkg::CHAR_LF);
      add_crlf();
      frame_bytes.push_back("A");
      frame_bytes.push_back(hhls_pkg::CHAR_CR);
      send_frame();
      // Longer run: the fifth and sixth CR/LF already count as body.
      repeat (5) frame_bytes.push_back(hhls_pkg::CHAR_CR);
      frame_bytes.push_back(hhls_pkg::CHAR_LF);
      send_frame();
   endtask

   // Keyword matching corner cases.
   task automatic test_keyword_cases();
      // Colon on the last byte does not count.
      add_text("content-length:", 0);
      send_frame();
      // One byte after the colon is enough.
      add_text("CONTENT-LENGTH:7", 0);
      send_frame();
      // Line ends right after the colon: found with value zero.
      add_text("Content-Length:", 0);
      frame_bytes.push_back(hhls_pkg::CHAR_CR);
      send_frame();
      // Restart on a stray c, skip non-digits, keep only the first keyword.
      add_text("ccontent-lengthcontent-length: 4x2", 1);
      add_crlf();
      add_text("Content-Length: 9", 0);
      add_crlf();
      add_crlf();
      add_text("ab", 0);
      send_frame();
   endtask

   // Value saturation at 32 bits and the digit stop on CR/LF.
   task automatic test_digit_saturation();
      add_text("Content-Length: 4294967295", 0);
      add_crlf();
      send_frame();
      add_text("content-length:4294967296", 0);
      send_frame();
      add_text("content-length:99999999999999999999", 0);
      add_crlf();
      add_crlf();
      send_frame();
      add_text("content-length:12", 0);
      frame_bytes.push_back(hhls_pkg::CHAR_CR);
      add_text("z34", 0);
      send_frame();
   endtask

   // Header end followed by a short body of random bytes.
   task automatic test_body_count();
      add_crlf();
      add_crlf();
      repeat (40) frame_bytes.push_back(8'($urandom_range(0, 255)));
      send_frame();
   endtask

   // Well-formed request: optional lines, keyword, value, header end, body.
   task automatic build_request();
      int n;
      if ($urandom_range(0, 1)) begin
         add_text("POST /u HTTP/1.1", 1);
         add_crlf();
      end
      if ($urandom_range(0, 3) == 0) begin
         add_text("Host: c", 1);
         add_crlf();
      end
      add_text("content-length:", 1);
      repeat ($urandom_range(0, 2)) frame_bytes.push_back(" ");
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
      repeat (n) begin
         if ($urandom_range(0, 9) == 0) frame_bytes.push_back("x");
         frame_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
      case ($urandom_range(0, 3))
         0:       frame_bytes.push_back(hhls_pkg::CHAR_LF);
         1:       frame_bytes.push_back(hhls_pkg::CHAR_CR);
         default: add_crlf();
      endcase
      if ($urandom_range(0, 2) == 0) begin
         add_text("Content-Length: 5", 1);
         add_crlf();
      end
      if ($urandom_range(0, 4) != 0) begin
         add_crlf();
      end
      repeat ($urandom_range(0, 24)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      // Sometimes append one more random byte; the keyword keeps the buffer nonempty.
      if ($urandom_range(0, 3) == 0) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Keyword cut short, sometimes right on the colon, then random tail.
   task automatic build_truncated();
      string keyword;
      keyword = "content-length:";
      add_text(keyword.substr(0, $urandom_range(0, 14)), 1);
      repeat ($urandom_range(0, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Noise heavy in CR, LF and c so runs and restarts happen often.
   task automatic build_noise();
      repeat ($urandom_range(1, 30)) begin
         case ($urandom_range(0, 7))
            0, 1:    frame_bytes.push_back(hhls_pkg::CHAR_CR);
            2, 3:    frame_bytes.push_back(hhls_pkg::CHAR_LF);
            4:       frame_bytes.push_back("c");
            default: frame_bytes.push_back(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic run_random_phase(input int sender_idle, input int receiver_stall,
                                   input int byte_budget);
      int start;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      start     = bytes_sent;
      while (bytes_sent - start < byte_budget) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: build_request();
            7:                   build_truncated();
            default:             build_noise();
         endcase
         send_frame();
      end
      // Pause the sender until all summaries are back before changing pace.
      wait_for_drain();
   endtask

   // Mostly well-formed requests across the four traffic shapes.
   task automatic test_random_traffic();
      run_random_phase(0, 0, 320);
      run_random_phase(76, 0, 320);
      run_random_phase(0, 76, 320);
      run_random_phase(12, 12, 320);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_beat  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_byte_extremes();
      test_keyword_cases();
      test_digit_saturation();
      test_body_count();
      wait_for_drain();
      test_random_traffic();

      wait_for_drain();
      // Let any stray beat surface through the input stage and result register.
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_summaries.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
